// ----- design/drt_pkg.sv -----
// Package with the widths, constants and result types of the drawdown tracker.
`timescale 1ns / 1ps

package drt_pkg;

  localparam int VALUE_BITS = 40;
  localparam int COUNT_BITS = 32;
  localparam int DD_BITS    = VALUE_BITS + 1;
  localparam int SUM_BITS   = 63;
  localparam int TS_BITS    = 44;
  localparam int DAY_BITS   = 18;

  // One day is 86400000 ms = 2^10 * 84375; the power of two is a shift.
  localparam longint unsigned MS_PER_DAY = 64'd86400000;
  localparam int DAY_SHIFT   = 10;
  localparam int DAY_ODD     = int'(MS_PER_DAY >> DAY_SHIFT);
  localparam int X_BITS      = TS_BITS - DAY_SHIFT;
  localparam int RECIP_SHIFT = X_BITS;
  localparam int RECIP_BITS  = 18;
  localparam longint unsigned DAY_RECIP = (64'd1 << RECIP_SHIFT) / DAY_ODD;

  localparam int IN_BITS        = TS_BITS + 2 * VALUE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 6 * DD_BITS + 2 * VALUE_BITS + 2 * COUNT_BITS + 2 * SUM_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [DD_BITS-1:0]    dd_t;
  typedef logic        [COUNT_BITS-1:0] count_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [SUM_BITS:0]     wide_sum_t;
  typedef logic        [DAY_BITS-1:0]   day_t;

  // Drawdown sums stop at -2^62.
  localparam wide_sum_t SUM_FLOOR = {2'b11, {(SUM_BITS - 1){1'b0}}};

  typedef struct packed {
    dd_t    dd;
    value_t peak;
    dd_t    worst;
    count_t bars;
    sum_t   total;
  } chan_res_t;

  typedef struct packed {
    dd_t eq_low;
    dd_t bal_low;
  } daily_res_t;

endpackage

// ----- design/drawdown_tracker.sv -----
// Top level of the drawdown tracker: stage registers, handshake and result register.
//
//   channel  dir  width  contents
//   s_axis   in   128    bars: timestamp_ms, balance, equity
//   m_axis   out  520    one result per bar: drawdowns, peaks, counts, sums
//
// One bar per cycle while the output accepts results; a bar's result passes the input
// register, two divider stages and the result register before it is valid.
// The day number comes from the two-stage reciprocal divider; the tracker
// state updates in the single cycle that loads the result register.
// Reset clears all tracker state and empties the pipeline.
// A stalled output holds the pipeline; stages with bubbles keep filling.
`timescale 1ns / 1ps

module drawdown_tracker import drt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata from bit 0: timestamp_ms[44], balance[40], equity[40], zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata from bit 0: equity_drawdown[41], balance_drawdown[41], equity_peak[40],
  // balance_peak[40], worst_equity_drawdown[41], worst_balance_drawdown[41],
  // equity_dd_bar_count[32], balance_dd_bar_count[32], equity_dd_total[63],
  // balance_dd_total[63], worst_equity_daily_drawdown[41],
  // worst_balance_daily_drawdown[41], zero pad
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic               v0_q, v1_q, v2_q, v3_q;
  logic               rdy0, rdy1, rdy2, rdy3;
  logic               upd;
  logic               seeded_q;
  logic [TS_BITS-1:0] ts0_q;
  value_t             bal0_q, eq0_q, bal1_q, eq1_q, bal2_q, eq2_q;
  day_t               day;
  chan_res_t          eq_res, bal_res, eq_res_q, bal_res_q;
  daily_res_t         daily_res, daily_q;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign upd  = v2_q && rdy3;

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      seeded_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (upd)  seeded_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      ts0_q  <= s_axis_tdata[TS_BITS-1:0];
      bal0_q <= s_axis_tdata[TS_BITS +: VALUE_BITS];
      eq0_q  <= s_axis_tdata[TS_BITS + VALUE_BITS +: VALUE_BITS];
    end
    if (rdy1) begin
      bal1_q <= bal0_q;
      eq1_q  <= eq0_q;
    end
    if (rdy2) begin
      bal2_q <= bal1_q;
      eq2_q  <= eq1_q;
    end
    if (upd) begin
      eq_res_q  <= eq_res;
      bal_res_q <= bal_res;
      daily_q   <= daily_res;
    end
  end

  drt_day_div u_day_div (
    .clk_i (clk_i),
    .en1_i (rdy1),
    .en2_i (rdy2),
    .ts_i  (ts0_q),
    .day_o (day)
  );

  drt_channel u_eq_chan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .seeded_i (seeded_q),
    .value_i  (eq2_q),
    .res_o    (eq_res)
  );

  drt_channel u_bal_chan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .seeded_i (seeded_q),
    .value_i  (bal2_q),
    .res_o    (bal_res)
  );

  drt_daily u_daily (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .day_i  (day),
    .eq_i   (eq2_q),
    .bal_i  (bal2_q),
    .res_o  (daily_res)
  );

  assign m_axis_tdata = {
    {(OUT_TDATA_BITS - OUT_BITS){1'b0}},
    daily_q.bal_low, daily_q.eq_low,
    bal_res_q.total, eq_res_q.total,
    bal_res_q.bars, eq_res_q.bars,
    bal_res_q.worst, eq_res_q.worst,
    bal_res_q.peak, eq_res_q.peak,
    bal_res_q.dd, eq_res_q.dd
  };

  // A drawdown is never positive, and the worst one is at or below the current one.
  a_dd_not_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(eq_res_q.dd) <= 0) && ($signed(bal_res_q.dd) <= 0))
    else $error("drawdown above zero");

  a_worst_below_dd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(eq_res_q.worst) <= $signed(eq_res_q.dd)) &&
                      ($signed(bal_res_q.worst) <= $signed(bal_res_q.dd)))
    else $error("worst drawdown above current drawdown");

  // The sum is negative exactly when some bar was counted in drawdown.
  a_count_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((eq_res_q.total != '0) == (eq_res_q.bars != '0)) &&
                      ((bal_res_q.total != '0) == (bal_res_q.bars != '0)))
    else $error("drawdown count and sum disagree");

  // Once a result is delivered the peaks stay seeded.
  a_seeded_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seeded_q)
    else $error("result without seeded peaks");

endmodule

// ----- design/drt_day_div.sv -----
// Two-stage pipelined division of the timestamp by the milliseconds of one day.
`timescale 1ns / 1ps

module drt_day_div import drt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en1_i,
  input  logic                 en2_i,
  input  logic [TS_BITS-1:0]   ts_i,
  output day_t                 day_o
);

  logic [X_BITS-1:0]            x_q;
  logic [X_BITS-1:0]            x_d;
  day_t                         qe_q, qe_d;
  day_t                         day_q, day_d;
  logic [X_BITS+RECIP_BITS-1:0] prod1;
  logic [X_BITS:0]              prod2;
  logic [X_BITS:0]              rem;

  // The estimate from the truncated reciprocal is the quotient or one below it.
  always_comb begin
    x_d   = ts_i[TS_BITS-1:DAY_SHIFT];
    prod1 = (X_BITS + RECIP_BITS)'(x_d) * (X_BITS + RECIP_BITS)'(DAY_RECIP);
    qe_d  = prod1[RECIP_SHIFT +: DAY_BITS];
  end

  always_comb begin
    prod2 = (X_BITS + 1)'(qe_q) * (X_BITS + 1)'(DAY_ODD);
    rem   = (X_BITS + 1)'(x_q) - prod2;
    day_d = qe_q + day_t'(rem >= (X_BITS + 1)'(DAY_ODD));
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      x_q  <= x_d;
      qe_q <= qe_d;
    end
    if (en2_i) begin
      day_q <= day_d;
    end
  end

  assign day_o = day_q;

endmodule

// ----- design/drt_channel.sv -----
// Peak, drawdown, worst drawdown and saturating bar count and sum of one channel.
`timescale 1ns / 1ps

module drt_channel import drt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      upd_i,
  input  logic      seeded_i,
  input  value_t    value_i,
  output chan_res_t res_o
);

  value_t    high_q, high_d;
  dd_t       low_q, low_d;
  count_t    bars_q, bars_d;
  sum_t      sum_q, sum_d;
  dd_t       dd;
  wide_sum_t sum_wide;

  always_comb begin
    high_d   = (!seeded_i || (value_i > high_q)) ? value_i : high_q;
    dd       = dd_t'(value_i) - dd_t'(high_d);
    sum_wide = wide_sum_t'(sum_q) + wide_sum_t'(dd);
    bars_d   = bars_q;
    sum_d    = sum_q;
    if (dd < 0) begin
      if (bars_q != '1) begin
        bars_d = bars_q + 1'b1;
      end
      if (sum_wide < SUM_FLOOR) begin
        sum_d = SUM_FLOOR[SUM_BITS-1:0];
      end else begin
        sum_d = sum_wide[SUM_BITS-1:0];
      end
    end
    low_d = (dd < low_q) ? dd : low_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '0;
      low_q  <= '0;
      bars_q <= '0;
      sum_q  <= '0;
    end else if (upd_i) begin
      high_q <= high_d;
      low_q  <= low_d;
      bars_q <= bars_d;
      sum_q  <= sum_d;
    end
  end

  assign res_o.dd    = dd;
  assign res_o.peak  = high_d;
  assign res_o.worst = low_d;
  assign res_o.bars  = bars_d;
  assign res_o.total = sum_d;

endmodule

// ----- design/drt_daily.sv -----
// Day opening values and worst intraday drawdown of both channels.
`timescale 1ns / 1ps

module drt_daily import drt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       upd_i,
  input  day_t       day_i,
  input  value_t     eq_i,
  input  value_t     bal_i,
  output daily_res_t res_o
);

  logic   seen_q;
  day_t   day_q;
  value_t open_eq_q, open_eq_d;
  value_t open_bal_q, open_bal_d;
  dd_t    low_eq_q, low_eq_d;
  dd_t    low_bal_q, low_bal_d;
  dd_t    d_eq, d_bal;
  logic   new_day;

  // Any change of day number opens a day, also a step back in time.
  always_comb begin
    new_day    = !seen_q || (day_i != day_q);
    open_eq_d  = new_day ? eq_i : open_eq_q;
    open_bal_d = new_day ? bal_i : open_bal_q;
    d_eq       = dd_t'(eq_i) - dd_t'(open_eq_d);
    d_bal      = dd_t'(bal_i) - dd_t'(open_bal_d);
    low_eq_d   = (d_eq < low_eq_q) ? d_eq : low_eq_q;
    low_bal_d  = (d_bal < low_bal_q) ? d_bal : low_bal_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      day_q      <= '0;
      open_eq_q  <= '0;
      open_bal_q <= '0;
      low_eq_q   <= '0;
      low_bal_q  <= '0;
    end else if (upd_i) begin
      seen_q     <= 1'b1;
      day_q      <= day_i;
      open_eq_q  <= open_eq_d;
      open_bal_q <= open_bal_d;
      low_eq_q   <= low_eq_d;
      low_bal_q  <= low_bal_d;
    end
  end

  assign res_o.eq_low  = low_eq_d;
  assign res_o.bal_low = low_bal_d;

endmodule

// ----- bench/tb_drawdown_tracker.sv -----
// Self-checking testbench for the drawdown tracker: streamed bars against a behavioral predictor.
`timescale 1ns / 1ps

module tb_drawdown_tracker;
  import drt_pkg::*;

  localparam longint unsigned MS_IN_DAY    = 64'd86_400_000;
  localparam longint unsigned BARS_MAX     = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint          TOTAL_FLOOR  = -(longint'(1) << (SUM_BITS - 1));
  localparam int              CYCLE_LIMIT  = 200_000;
  localparam int              SHOWN_ERRORS = 10;
  localparam int              RANDOM_BARS  = 1750;
  localparam value_t          VAL_MAX      = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam value_t          VAL_MIN      = {1'b1, {(VALUE_BITS - 1){1'b0}}};
  localparam logic [TS_BITS-1:0] TS_MAX    = '1;

  // Request layout on s_axis_tdata, lowest field last.
  typedef struct packed {
    logic [IN_TDATA_BITS-IN_BITS-1:0] pad;
    value_t                           equity;
    value_t                           balance;
    logic [TS_BITS-1:0]               ts;
  } bar_t;

  // Result layout on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_TDATA_BITS-OUT_BITS-1:0] pad;
    dd_t    bal_daily;
    dd_t    eq_daily;
    sum_t   bal_total;
    sum_t   eq_total;
    count_t bal_bars;
    count_t eq_bars;
    dd_t    bal_worst;
    dd_t    eq_worst;
    value_t bal_peak;
    value_t eq_peak;
    dd_t    bal_dd;
    dd_t    eq_dd;
  } bar_res_t;

  typedef struct {
    longint          peak;
    longint          worst;
    longint unsigned bars;
    longint          total;
  } chan_track_t;

  typedef struct {
    bar_t     bar;
    bit       fixed;
    bar_res_t res;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  // Tracker copy kept by the bench.
  bit          peaks_seeded;
  chan_track_t eq_chan;
  chan_track_t bal_chan;
  bit          day_open_valid;
  day_t        open_day;
  longint      eq_open;
  longint      bal_open;
  longint      eq_daily_low;
  longint      bal_daily_low;

  bar_res_t  bar_results_q[$];
  bit        row_fixed     = 1'b0;
  bar_res_t  row_fixed_res = '0;
  int        fail_count    = 0;
  int        cycles        = 0;
  int        burst_left    = 0;
  int        rx_left       = 0;
  rx_mode_e  rx_mode       = RX_OPEN;

  drawdown_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint widen(input value_t v);
    return longint'(v);
  endfunction

  function automatic longint track_chan(input longint v, input bit seeded,
                                        inout chan_track_t c);
    longint dd;
    if (!seeded || v > c.peak) c.peak = v;
    dd = v - c.peak;
    if (dd < 0) begin
      if (c.bars < BARS_MAX) c.bars++;
      c.total += dd;
      if (c.total < TOTAL_FLOOR) c.total = TOTAL_FLOOR;
    end
    if (dd < c.worst) c.worst = dd;
    return dd;
  endfunction

  function automatic bar_res_t advance_tracker(input bar_t b);
    longint   eq_v;
    longint   bal_v;
    longint   eq_dd;
    longint   bal_dd;
    longint   eq_move;
    longint   bal_move;
    day_t     day;
    bar_res_t r;
    eq_v  = widen(b.equity);
    bal_v = widen(b.balance);
    day   = day_t'(64'(b.ts) / MS_IN_DAY);
    eq_dd  = track_chan(eq_v, peaks_seeded, eq_chan);
    bal_dd = track_chan(bal_v, peaks_seeded, bal_chan);
    peaks_seeded = 1'b1;
    // A backwards step into an earlier day opens that day again.
    if (!day_open_valid || day != open_day) begin
      day_open_valid = 1'b1;
      open_day       = day;
      eq_open        = eq_v;
      bal_open       = bal_v;
    end
    eq_move  = eq_v - eq_open;
    bal_move = bal_v - bal_open;
    if (eq_move < eq_daily_low) eq_daily_low = eq_move;
    if (bal_move < bal_daily_low) bal_daily_low = bal_move;
    r           = '0;
    r.eq_dd     = dd_t'(eq_dd);
    r.bal_dd    = dd_t'(bal_dd);
    r.eq_peak   = value_t'(eq_chan.peak);
    r.bal_peak  = value_t'(bal_chan.peak);
    r.eq_worst  = dd_t'(eq_chan.worst);
    r.bal_worst = dd_t'(bal_chan.worst);
    r.eq_bars   = count_t'(eq_chan.bars);
    r.bal_bars  = count_t'(bal_chan.bars);
    r.eq_total  = sum_t'(eq_chan.total);
    r.bal_total = sum_t'(bal_chan.total);
    r.eq_daily  = dd_t'(eq_daily_low);
    r.bal_daily = dd_t'(bal_daily_low);
    return r;
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) report($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // Results leave before the bar taken at the same edge is predicted.
  always @(posedge clk_i) begin
    bar_res_t got;
    bar_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = bar_res_t'(m_axis_tdata);
        if (bar_results_q.size() == 0) begin
          report("result arrived with no bar waiting for it");
        end else begin
          want = bar_results_q.pop_front();
          check_field("equity_drawdown", want.eq_dd, got.eq_dd);
          check_field("balance_drawdown", want.bal_dd, got.bal_dd);
          check_field("equity_peak", want.eq_peak, got.eq_peak);
          check_field("balance_peak", want.bal_peak, got.bal_peak);
          check_field("worst_equity_drawdown", want.eq_worst, got.eq_worst);
          check_field("worst_balance_drawdown", want.bal_worst, got.bal_worst);
          check_field("equity_dd_bar_count", want.eq_bars, got.eq_bars);
          check_field("balance_dd_bar_count", want.bal_bars, got.bal_bars);
          check_field("equity_dd_total", want.eq_total, got.eq_total);
          check_field("balance_dd_total", want.bal_total, got.bal_total);
          check_field("worst_equity_daily_drawdown", want.eq_daily, got.eq_daily);
          check_field("worst_balance_daily_drawdown", want.bal_daily, got.bal_daily);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_tracker(bar_t'(s_axis_tdata));
        if (row_fixed) want = row_fixed_res;
        bar_results_q = {bar_results_q, want};
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ((rx_left % 8) < 5);
    endcase
  end

  task automatic send_bar(input bar_t b, input bit fixed, input bar_res_t res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    row_fixed     <= fixed;
    row_fixed_res <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic bar_t mk_bar(input logic [TS_BITS-1:0] ts, input value_t bal,
                                  input value_t eq);
    bar_t b;
    b         = '0;
    b.ts      = ts;
    b.balance = bal;
    b.equity  = eq;
    return b;
  endfunction

  initial begin
    stim_row_t             opening[11];
    stim_row_t             closing[6];
    bar_res_t              seed_res;
    bar_res_t              flat_res;
    bar_res_t              floor_res;
    bar_t                  b;
    logic [TS_BITS-1:0]    ts;
    logic [TS_BITS-1:0]    ts_far;
    longint                eq_lvl;
    longint                bal_lvl;
    int                    pick;

    peaks_seeded   = 1'b0;
    eq_chan        = '{0, 0, 0, 0};
    bal_chan       = '{0, 0, 0, 0};
    day_open_valid = 1'b0;
    open_day       = '0;
    eq_open        = 0;
    bal_open       = 0;
    eq_daily_low   = 0;
    bal_daily_low  = 0;

    // First bar seeds both peaks at the minimum, so nothing is in drawdown.
    seed_res          = '0;
    seed_res.eq_peak  = VAL_MIN;
    seed_res.bal_peak = VAL_MIN;
    // A rise to zero moves both peaks to zero.
    flat_res          = '0;
    // Back to the minimum on the same day: a drawdown of 2^39 on both channels.
    floor_res           = '0;
    floor_res.eq_dd     = dd_t'(VAL_MIN);
    floor_res.bal_dd    = dd_t'(VAL_MIN);
    floor_res.eq_worst  = dd_t'(VAL_MIN);
    floor_res.bal_worst = dd_t'(VAL_MIN);
    floor_res.eq_bars   = count_t'(1);
    floor_res.bal_bars  = count_t'(1);
    floor_res.eq_total  = sum_t'(VAL_MIN);
    floor_res.bal_total = sum_t'(VAL_MIN);

    opening[0]  = '{mk_bar(44'd0, VAL_MIN, VAL_MIN), 1'b1, seed_res};
    opening[1]  = '{mk_bar(44'd2, 40'sd0, 40'sd0), 1'b1, flat_res};
    opening[2]  = '{mk_bar(44'd3, VAL_MIN, VAL_MIN), 1'b1, floor_res};
    opening[3]  = '{mk_bar(44'd86_399_999, 40'sd0, -40'sd1), 1'b0, '0};
    opening[4]  = '{mk_bar(44'd86_400_000, 40'sd100, 40'sd100), 1'b0, '0};
    opening[5]  = '{mk_bar(44'd86_400_001, 40'sd100, 40'sd100), 1'b0, '0};
    opening[6]  = '{mk_bar(44'd86_400_002, 40'sd50, 40'sd150), 1'b0, '0};
    opening[7]  = '{mk_bar(44'd10, -40'sd500, 40'sd200), 1'b0, '0};
    opening[8]  = '{mk_bar(44'd11, -40'sd600, 40'sd180), 1'b0, '0};
    opening[9]  = '{mk_bar(44'd12, VAL_MIN, 40'sd0), 1'b0, '0};
    opening[10] = '{mk_bar(44'd172_800_000, 40'sd900, 40'sd1000), 1'b0, '0};

    // Maximum values pin the peaks for good, since reset happens only once,
    // so those rows run after the random part.
    closing[0] = '{mk_bar(TS_MAX, 40'h55_5555_5555, 40'hAA_AAAA_AAAA), 1'b0, '0};
    closing[1] = '{mk_bar(44'h555_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555),
                   1'b0, '0};
    closing[2] = '{mk_bar(44'hAAA_AAAA_AAAA, VAL_MAX, VAL_MAX), 1'b0, '0};
    closing[3] = '{mk_bar(44'hAAA_AAAA_AAAB, VAL_MIN, VAL_MIN), 1'b0, '0};
    closing[4] = '{mk_bar(44'hAAA_AAAA_AAAC, VAL_MAX, VAL_MIN), 1'b0, '0};
    closing[5] = '{mk_bar(44'd0, VAL_MIN, VAL_MAX), 1'b0, '0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) send_bar(opening[i].bar, opening[i].fixed, opening[i].res);

    // Mostly a market-like series: time moves forward a few bars per day and
    // both channels walk with an upward drift, so peaks keep moving.
    ts      = 44'd172_800_000;
    eq_lvl  = 1000;
    bal_lvl = 900;
    for (int n = 0; n < RANDOM_BARS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        ts_far = TS_BITS'({$urandom, $urandom});
        ts     = ts_far;
      end else if (pick < 7) begin
        ts = ts - TS_BITS'($urandom_range(1, 200_000_000));
      end else if (pick < 10) begin
        ts = ts + TS_BITS'({$urandom_range(0, 255), $urandom});
      end else begin
        ts = ts + TS_BITS'($urandom_range(0, 25_000_000));
      end
      eq_lvl  += longint'($urandom_range(0, 7000)) - 3200;
      bal_lvl += longint'($urandom_range(0, 5000)) - 2300;
      if (pick >= 10 && pick < 14) eq_lvl += longint'($urandom_range(0, 1 << 24));
      if (pick >= 14 && pick < 18) bal_lvl += longint'($urandom_range(0, 1 << 24));
      if (pick >= 18 && pick < 22) eq_lvl -= longint'($urandom_range(0, 1 << 22));
      if (pick >= 22 && pick < 26) bal_lvl -= longint'($urandom_range(0, 1 << 22));
      b = mk_bar(ts, value_t'(bal_lvl), value_t'(eq_lvl));
      // Noise: negative values with random low bits never lift a peak.
      if (pick >= 92 && pick < 96) b.equity = {1'b1, 7'($urandom), $urandom};
      if (pick >= 96) b.balance = {1'b1, 7'($urandom), $urandom};
      send_bar(b, 1'b0, '0);
    end

    foreach (closing[i]) send_bar(closing[i].bar, closing[i].fixed, closing[i].res);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (bar_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
